>>> rtl/assert_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on an explicit clock, disabled while reset is high.
`define TGA_ASSERT_CR(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on the module's clock and reset.
`define TGA_ASSERT(lbl, prop, msg) \
   `TGA_ASSERT_CR(lbl, clock, reset, prop, msg)

`endif

>>> rtl/tga_pkg.sv
package tga_pkg;

   // Result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_FORMAT = 2'd2;
   localparam logic [1:0] KIND_TRUNC  = 2'd3;

   // Parser phases
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_PIXELS = 2'd1;
   localparam logic [1:0] PH_SKIP   = 2'd2;

   // Header layout
   localparam int          HDR_FIXED_LEN = 12;
   localparam logic [4:0]  HDR_POS_WLO   = 5'd12;
   localparam logic [4:0]  HDR_POS_WHI   = 5'd13;
   localparam logic [4:0]  HDR_POS_HLO   = 5'd14;
   localparam logic [4:0]  HDR_POS_HHI   = 5'd15;
   localparam logic [4:0]  HDR_POS_DEPTH = 5'd16;
   localparam logic [4:0]  HDR_POS_LAST  = 5'd17;
   localparam logic [7:0]  WANTED_DEPTH  = 8'd32;

   // Fixed part of an uncompressed true-color header
   localparam logic [7:0] HDR_BYTES [HDR_FIXED_LEN] = '{
      8'd0, 8'd0, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
   };

   // Default response queue depth
   localparam int RSP_DEPTH = 8;

   // One result word
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        last_pixel;
   } rsp_type;

   // Results produced by one byte: count 0..2, first in slot 0
   typedef struct packed {
      logic [1:0] count;
      rsp_type    r0;
      rsp_type    r1;
   } rsp_pair_type;

endpackage

>>> rtl/tga_parser.sv
`include "assert_macros.svh"

module tga_parser
   import tga_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         byte_valid,
   input  logic [7:0]   data_byte,
   input  logic         end_of_file,
   output logic         busy,
   output rsp_pair_type results
);

   // Input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_eof_ff;

   // Parse state
   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  hdr_pos_ff, hdr_pos_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  depth_ff, depth_in;
   logic [31:0] remain_ff, remain_in;
   logic [1:0]  bip_ff, bip_in;
   logic [23:0] held_ff, held_in;

   logic [31:0] remain_dec;
   logic        is_last;
   logic        hdr_fail;
   rsp_type     fmt_rsp;
   rsp_type     trunc_rsp;

   assign busy = in_valid_ff;

   // Capture the incoming byte
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= byte_valid;
      end
      in_byte_ff <= data_byte;
      in_eof_ff  <= end_of_file;
   end

   // Decode one byte against the parse state
   always_comb begin
      phase_in   = phase_ff;
      hdr_pos_in = hdr_pos_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      depth_in   = depth_ff;
      remain_in  = remain_ff;
      bip_in     = bip_ff;
      held_in    = held_ff;
      results    = '0;
      hdr_fail   = 1'b0;
      remain_dec = (remain_ff != 32'd0) ? remain_ff - 32'd1 : 32'd0;
      is_last    = (remain_dec == 32'd0);
      fmt_rsp      = '0;
      fmt_rsp.kind = KIND_FORMAT;
      trunc_rsp              = '0;
      trunc_rsp.kind         = KIND_TRUNC;
      trunc_rsp.image_width  = width_ff;
      trunc_rsp.image_height = height_ff;

      if (in_valid_ff) begin
         case (phase_ff)
            PH_HEADER: begin
               if (hdr_pos_ff < 5'(HDR_FIXED_LEN)) begin
                  hdr_fail = (in_byte_ff != HDR_BYTES[hdr_pos_ff[3:0]]);
               end else begin
                  case (hdr_pos_ff)
                     HDR_POS_WLO:   width_in[7:0]   = in_byte_ff;
                     HDR_POS_WHI:   width_in[15:8]  = in_byte_ff;
                     HDR_POS_HLO:   height_in[7:0]  = in_byte_ff;
                     HDR_POS_HHI:   height_in[15:8] = in_byte_ff;
                     HDR_POS_DEPTH: depth_in        = in_byte_ff;
                     default: ;
                  endcase
               end
               if (hdr_fail) begin
                  results.count = 2'd1;
                  results.r0    = fmt_rsp;
                  phase_in      = PH_SKIP;
               end else if (hdr_pos_ff >= HDR_POS_LAST) begin
                  if (width_ff == 16'd0 || height_ff == 16'd0 || depth_ff != WANTED_DEPTH) begin
                     results.count = 2'd1;
                     results.r0    = fmt_rsp;
                     phase_in      = PH_SKIP;
                  end else begin
                     results.count           = 2'd1;
                     results.r0              = '0;
                     results.r0.kind         = KIND_HEADER;
                     results.r0.image_width  = width_ff;
                     results.r0.image_height = height_ff;
                     remain_in = {16'd0, width_ff} * {16'd0, height_ff};
                     bip_in    = 2'd0;
                     held_in   = '0;
                     phase_in  = PH_PIXELS;
                     if (in_eof_ff) begin
                        results.count = 2'd2;
                        results.r1    = trunc_rsp;
                     end
                  end
               end else begin
                  hdr_pos_in = hdr_pos_ff + 5'd1;
                  if (in_eof_ff) begin
                     results.count = 2'd1;
                     results.r0    = fmt_rsp;
                  end
               end
            end
            PH_PIXELS: begin
               if (bip_ff != 2'd3) begin
                  case (bip_ff)
                     2'd0:    held_in[7:0]   = in_byte_ff;
                     2'd1:    held_in[15:8]  = in_byte_ff;
                     default: held_in[23:16] = in_byte_ff;
                  endcase
                  bip_in = bip_ff + 2'd1;
               end else begin
                  remain_in               = remain_dec;
                  results.count           = 2'd1;
                  results.r0.kind         = KIND_PIXEL;
                  results.r0.image_width  = width_ff;
                  results.r0.image_height = height_ff;
                  results.r0.red          = held_ff[23:16];
                  results.r0.green        = held_ff[15:8];
                  results.r0.blue         = held_ff[7:0];
                  results.r0.alpha        = in_byte_ff;
                  results.r0.last_pixel   = is_last;
                  bip_in  = 2'd0;
                  held_in = '0;
                  if (is_last) begin
                     phase_in = PH_SKIP;
                  end
               end
               // Truncation follows any pixel this byte finished
               if (in_eof_ff && phase_in == PH_PIXELS) begin
                  if (results.count == 2'd0) begin
                     results.count = 2'd1;
                     results.r0    = trunc_rsp;
                  end else begin
                     results.count = 2'd2;
                     results.r1    = trunc_rsp;
                  end
               end
            end
            default: ;
         endcase

         // Rearm on the end-of-file mark
         if (in_eof_ff) begin
            phase_in   = PH_HEADER;
            hdr_pos_in = '0;
            width_in   = '0;
            height_in  = '0;
            depth_in   = '0;
            remain_in  = '0;
            bip_in     = '0;
            held_in    = '0;
         end
      end
   end

   // Advance the parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_pos_ff <= '0;
         width_ff   <= '0;
         height_ff  <= '0;
         depth_ff   <= '0;
         remain_ff  <= '0;
         bip_ff     <= '0;
         held_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         hdr_pos_ff <= hdr_pos_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         depth_ff   <= depth_in;
         remain_ff  <= remain_in;
         bip_ff     <= bip_in;
         held_ff    <= held_in;
      end
   end

   `TGA_ASSERT(a_eof_rearms, in_valid_ff && in_eof_ff |=> phase_ff == PH_HEADER && hdr_pos_ff == 5'd0, "end of file did not rearm parser")
   `TGA_ASSERT(a_second_is_trunc, results.count == 2'd2 |-> results.r1.kind == KIND_TRUNC, "second result is not a truncation")
   `TGA_ASSERT(a_pixels_after_header, phase_ff == PH_PIXELS |-> hdr_pos_ff == HDR_POS_LAST && width_ff != 16'd0, "pixel phase without a full header")

endmodule

>>> rtl/tga_rsp_fifo.sv
`include "assert_macros.svh"

module tga_rsp_fifo
   import tga_pkg::*;
#(
   parameter int DEPTH = RSP_DEPTH
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         inflight,
   input  rsp_pair_type wr_pair,
   output logic         space_ok,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_word
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

   rsp_type        mem [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [PW-1:0]  wr_ptr_nx;
   logic           pop;
   logic [CW+1:0]  need;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      ptr_next = (p == PTR_LAST) ? '0 : p + PW'(1);
   endfunction

   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = mem[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign wr_ptr_nx = ptr_next(wr_ptr_ff);

   // Room for the byte in flight and one more, two words each
   assign need     = (CW+2)'(count_ff) + (inflight ? (CW+2)'(2) : '0) + (CW+2)'(2);
   assign space_ok = (need <= (CW+2)'(DEPTH));

   // Pointer and level update
   always_comb begin
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      case (wr_pair.count)
         2'd1:    wr_ptr_in = wr_ptr_nx;
         2'd2:    wr_ptr_in = ptr_next(wr_ptr_nx);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + CW'(wr_pair.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store up to two words per cycle
   always_ff @(posedge clock) begin
      if (wr_pair.count != 2'd0) begin
         mem[wr_ptr_ff] <= wr_pair.r0;
      end
      if (wr_pair.count == 2'd2) begin
         mem[wr_ptr_nx] <= wr_pair.r1;
      end
   end

   `TGA_ASSERT(a_no_overflow, (CW+2)'(count_ff) + (CW+2)'(wr_pair.count) <= (CW+2)'(DEPTH) + (CW+2)'(pop), "response queue overflow")
   `TGA_ASSERT(a_level_bound, count_ff <= CW'(DEPTH), "response queue level out of range")

endmodule

>>> rtl/tga_rgba_stream_decoder.sv
// A result word is offered once its byte has passed the input register and reached the queue.
// Throughput: one byte per cycle while req_tready is high; the output drains one word per cycle
// while rsp_tready is high. A default eight-word response queue absorbs bytes raising two words
// (header or pixel plus truncation); input stalls only when the queue cannot hold two words each
// for the byte in flight and the next one.
// Reset: synchronous, active high; rearms the parser to the header phase and empties the queue.
module tga_rgba_stream_decoder
   import tga_pkg::*;
#(
   parameter int DEPTH = RSP_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [15:0] image_width, [31:16] image_height, [39:32] red,
                                    // [47:40] green, [55:48] blue, [63:56] alpha
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);

   logic         busy;
   logic         space_ok;
   rsp_pair_type pair;
   rsp_type      word;

   assign req_tready = space_ok;

   tga_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_tvalid && req_tready),
      .data_byte   (req_tdata),
      .end_of_file (req_tlast),
      .busy        (busy),
      .results     (pair)
   );

   tga_rsp_fifo #(
      .DEPTH (DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .inflight  (busy),
      .wr_pair   (pair),
      .space_ok  (space_ok),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_word  (word)
   );

   // Pack the result word
   assign rsp_tdata = {word.alpha, word.blue, word.green, word.red,
                       word.image_height, word.image_width};
   assign rsp_tuser = word.kind;
   assign rsp_tlast = word.last_pixel;

endmodule
